// ===== rtl/core/pdt_pkg.sv =====
`timescale 1ns / 1ps
package pdt_pkg;

  // Table capacity and identifier width.
  localparam int TABLE_DEPTH = 1024;
  localparam int ID_WIDTH    = 32;

  // Fixed field widths of one word.
  localparam int KEY_W     = 64;
  localparam int KIND_W    = 16;
  localparam int NODE_ID_W = 32;

  // The table is spread over a row of cells. Each cell owns one bank, and
  // entry e sits in cell (e mod CELL_COUNT) at row (e div CELL_COUNT).
  localparam int CELL_COUNT = (TABLE_DEPTH < 8) ? TABLE_DEPTH : 8;
  localparam int BANK_DEPTH = (TABLE_DEPTH + CELL_COUNT - 1) / CELL_COUNT;
  localparam int CELL_W     = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int ROW_W      = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int ROWC_W     = $clog2(BANK_DEPTH + 1);
  localparam int FILL_W     = $clog2(TABLE_DEPTH + 1);

  localparam logic [ID_WIDTH-1:0] ID_MIN = {1'b1, {(ID_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic [KEY_W-1:0]  lat;
    logic [KEY_W-1:0]  lon;
    logic [KIND_W-1:0] kind;
  } key_t;

  typedef struct packed {
    key_t                 key;
    logic [NODE_ID_W-1:0] id;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Search token that walks down the cell row, one per table row.
  typedef struct packed {
    logic                 vld;
    logic                 last;
    logic [ROW_W-1:0]     row;
    logic                 hit;
    logic [NODE_ID_W-1:0] id;
  } tok_t;

  // Append request, shared by all cells; each cell has its own enable.
  typedef struct packed {
    logic [ROW_W-1:0] row;
    entry_t           data;
  } wr_t;

  // IEEE equality on raw double bit patterns: a NaN equals nothing and the
  // two zeros are equal.
  function automatic logic dbl_equal(input logic [KEY_W-1:0] a,
                                     input logic [KEY_W-1:0] b);
    logic nan_a;
    logic nan_b;
    logic zeros;
    nan_a = (a[62:52] == 11'h7ff) && (a[51:0] != 52'd0);
    nan_b = (b[62:52] == 11'h7ff) && (b[51:0] != 52'd0);
    zeros = (a[62:0] == 63'd0) && (b[62:0] == 63'd0);
    return !nan_a && !nan_b && (zeros || (a == b));
  endfunction

endpackage

// ===== rtl/core/pdt_ram.sv =====
`timescale 1ns / 1ps
module pdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/pdt_cell.sv =====
`timescale 1ns / 1ps
module pdt_cell
  import pdt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  key_t              key,
  input  logic [ROWC_W-1:0] fill_row,
  input  logic              below_fill,
  input  logic              we,
  input  wr_t               wr,
  input  tok_t              tok_in,
  output tok_t              tok_out
);

  tok_t               tok_a_r;
  tok_t               tok_b_r;
  tok_t               tok_b_nxt;
  logic [ENTRY_W-1:0] rd_data;
  entry_t             ent;
  logic               ent_valid;
  logic               match;

  // Bank read is issued as the token arrives; data lines up with stage A.
  pdt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (BANK_DEPTH)
  ) u_bank (
    .clk   (clk),
    .we    (we),
    .waddr (wr.row),
    .wdata (wr.data),
    .raddr (tok_in.row),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_a_r.vld <= 1'b0;
      tok_b_r.vld <= 1'b0;
    end else begin
      tok_a_r <= tok_in;
      tok_b_r <= tok_b_nxt;
    end
  end

  always_comb begin
    ent       = entry_t'(rd_data);
    // Only entries below the fill point were ever written.
    ent_valid = (ROWC_W'(tok_a_r.row) < fill_row) ||
                ((ROWC_W'(tok_a_r.row) == fill_row) && below_fill);
    match     = ent_valid && (ent.key.kind == key.kind) &&
                dbl_equal(ent.key.lat, key.lat) && dbl_equal(ent.key.lon, key.lon);
    tok_b_nxt = tok_a_r;
    if (tok_a_r.vld && !tok_a_r.hit && match) begin
      tok_b_nxt.hit = 1'b1;
      tok_b_nxt.id  = ent.id;
    end
  end

  assign tok_out = tok_b_r;

endmodule

// ===== rtl/core/point_dedup_id_table.sv =====
`timescale 1ns / 1ps
// Channel   | Handshake              | Word fields
// ----------+------------------------+-------------------------------------------------
// input     | start / busy           | in_lat_bits, in_lon_bits, in_point_kind
// result    | out_valid (strobe)     | out_node_id, out_is_new, out_table_full,
//           |                        | out_id_exhausted
//
// A word is taken at a rising edge where start is high and busy is low.
// A kind-zero word goes straight to the finishing state; it is never searched or stored.
// Any other kind scans R rows, R = stored entries / CELL_COUNT + 1 capped at BANK_DEPTH,
// and then waits for the last search token to walk through the cell row.
// The result strobes in the same cycle that busy falls.
// Reset is synchronous and empties the table and sets the next identifier to -1.
// The receiver cannot stall: every result is shown for exactly one cycle.
module point_dedup_id_table_core
  import pdt_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [KEY_W-1:0]            in_lat_bits,
  input  logic [KEY_W-1:0]            in_lon_bits,
  input  logic signed [KIND_W-1:0]    in_point_kind,
  output logic                        out_valid,
  output logic signed [NODE_ID_W-1:0] out_node_id,
  output logic                        out_is_new,
  output logic                        out_table_full,
  output logic                        out_id_exhausted
);

  // Controller states. SCAN issues one search token per table row into the
  // first cell, WAIT lets the tokens drain out of the last cell, and FIN
  // settles the result and appends the entry on a miss of a nonzero kind while there is room.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]           state_r;
  logic [1:0]           state_nxt;
  key_t                 key_r;
  logic [ROW_W-1:0]     scan_row_r;
  logic [ROW_W-1:0]     last_row_r;
  logic                 hit_r;
  logic [NODE_ID_W-1:0] hit_id_r;
  logic [FILL_W-1:0]    fill_count_r;
  logic [ROWC_W-1:0]    fill_row_r;
  logic [CELL_W-1:0]    fill_cell_r;
  logic [ID_WIDTH-1:0]  next_id_r;
  logic [ID_WIDTH-1:0]  next_id_nxt;

  logic                 out_valid_r;
  logic [NODE_ID_W-1:0] out_node_id_r;
  logic                 out_is_new_r;
  logic                 out_table_full_r;
  logic                 out_id_exhausted_r;

  logic                 take;
  logic                 fin;
  logic                 kind_zero;
  logic                 table_room;
  logic                 id_exh;
  logic                 wr_go;
  logic signed [63:0]   id_ext;
  logic [NODE_ID_W-1:0] alloc_id;
  logic [ROW_W-1:0]     last_row_in;
  tok_t                 issue_tok;
  tok_t                 chain [CELL_COUNT+1];
  wr_t                  wr;

  assign busy = (state_r != ST_IDLE);
  assign take = start && !busy;
  assign fin  = (state_r == ST_FIN);

  // The scan covers every row that holds an entry; a full table covers the
  // whole bank. An empty table still scans row zero, where nothing is valid.
  assign last_row_in = (fill_row_r >= ROWC_W'(BANK_DEPTH)) ? ROW_W'(BANK_DEPTH - 1)
                                                           : fill_row_r[ROW_W-1:0];

  always_comb begin
    issue_tok      = '0;
    issue_tok.vld  = (state_r == ST_SCAN);
    issue_tok.last = (scan_row_r == last_row_r);
    issue_tok.row  = scan_row_r;
  end

  assign chain[0] = issue_tok;

  // The search row: each cell compares its bank entry at the token's row
  // against the held key and passes the token on through its stage A and stage B registers.
  for (genvar k = 0; k < CELL_COUNT; k++) begin : g_cell
    pdt_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .key        (key_r),
      .fill_row   (fill_row_r),
      .below_fill (CELL_W'(k) < fill_cell_r),
      .we         (wr_go && (fill_cell_r == CELL_W'(k))),
      .wr         (wr),
      .tok_in     (chain[k]),
      .tok_out    (chain[k+1])
    );
  end

  // Identifier as it leaves the block: the counter sign-extended, then cut
  // to the width of the result field.
  assign id_ext   = 64'(signed'(next_id_r));
  assign alloc_id = id_ext[NODE_ID_W-1:0];

  always_comb begin
    kind_zero   = (key_r.kind == '0);
    table_room  = (fill_count_r != FILL_W'(TABLE_DEPTH));
    id_exh      = (next_id_r == ID_MIN);
    wr_go       = fin && !kind_zero && !hit_r && table_room;
    wr.row      = fill_row_r[ROW_W-1:0];
    wr.data     = {key_r, alloc_id};
    next_id_nxt = next_id_r;
    // The counter saturates at its minimum and repeats that value.
    if (fin && !hit_r && !id_exh) begin
      next_id_nxt = next_id_r - ID_WIDTH'(1);
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = (in_point_kind == '0) ? ST_FIN : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_row_r == last_row_r) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (chain[CELL_COUNT].vld && chain[CELL_COUNT].last) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      hit_r        <= 1'b0;
      fill_count_r <= '0;
      fill_row_r   <= '0;
      fill_cell_r  <= '0;
      next_id_r    <= '1;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      next_id_r   <= next_id_nxt;
      out_valid_r <= fin;

      // Only one word is in flight, so any hit leaving the row is ours.
      if (take) begin
        hit_r <= 1'b0;
      end else if (chain[CELL_COUNT].vld && chain[CELL_COUNT].hit) begin
        hit_r <= 1'b1;
      end

      // Entries are appended across the cells first, then down the rows.
      if (wr_go) begin
        fill_count_r <= fill_count_r + FILL_W'(1);
        if (fill_cell_r == CELL_W'(CELL_COUNT - 1)) begin
          fill_cell_r <= '0;
          fill_row_r  <= fill_row_r + ROWC_W'(1);
        end else begin
          fill_cell_r <= fill_cell_r + CELL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      key_r.lat  <= in_lat_bits;
      key_r.lon  <= in_lon_bits;
      key_r.kind <= in_point_kind;
      scan_row_r <= '0;
      last_row_r <= last_row_in;
    end else if (state_r == ST_SCAN) begin
      scan_row_r <= scan_row_r + ROW_W'(1);
    end
    if (chain[CELL_COUNT].vld && chain[CELL_COUNT].hit) begin
      hit_id_r <= chain[CELL_COUNT].id;
    end
    if (fin) begin
      out_node_id_r      <= hit_r ? hit_id_r : alloc_id;
      out_is_new_r       <= !hit_r;
      out_table_full_r   <= !hit_r && !kind_zero && !table_room;
      out_id_exhausted_r <= !hit_r && id_exh;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_node_id      = out_node_id_r;
  assign out_is_new       = out_is_new_r;
  assign out_table_full   = out_table_full_r;
  assign out_id_exhausted = out_id_exhausted_r;

  // A result strobe always follows the finishing cycle of the controller.
  a_strobe_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(state_r) == ST_FIN))
    else $error("result strobe without a finishing cycle");

  // A table hit must not consume an identifier.
  a_hit_keeps_id: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_is_new) |-> (next_id_r == $past(next_id_r)))
    else $error("identifier counter moved on a table hit");

  // A dropped miss is only reported when the table really is full.
  a_full_is_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_table_full) |-> (fill_count_r == FILL_W'(TABLE_DEPTH)))
    else $error("table reported full below capacity");

  // Exhaustion leaves the counter parked at its minimum.
  a_exh_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_id_exhausted) |-> (next_id_r == ID_MIN))
    else $error("counter left its minimum after exhaustion");

  // Search tokens only leave the cell row while a search is running.
  a_tokens_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    chain[CELL_COUNT].vld |-> ((state_r == ST_SCAN) || (state_r == ST_WAIT)))
    else $error("search token outside of a search");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the point deduplication and id allocation core.
module tb;
  import pdt_pkg::*;

  // One result word as the core reports it.
  typedef struct packed {
    logic [NODE_ID_W-1:0] node_id;
    logic                 is_new;
    logic                 table_full;
    logic                 id_exhausted;
  } id_result_t;

  // Special double bit patterns used by the directed words.
  localparam logic [KEY_W-1:0] POS_ZERO  = 64'h0000_0000_0000_0000;
  localparam logic [KEY_W-1:0] NEG_ZERO  = 64'h8000_0000_0000_0000;
  localparam logic [KEY_W-1:0] POS_INF   = 64'h7FF0_0000_0000_0000;
  localparam logic [KEY_W-1:0] NEG_INF   = 64'hFFF0_0000_0000_0000;
  localparam logic [KEY_W-1:0] QUIET_NAN = 64'h7FF8_0000_0000_0000;
  localparam logic [KEY_W-1:0] TINY_NAN  = 64'h7FF0_0000_0000_0001;
  localparam logic [KEY_W-1:0] MAX_REAL  = 64'h7FEF_FFFF_FFFF_FFFF;
  localparam logic [KEY_W-1:0] MIN_REAL  = 64'hFFEF_FFFF_FFFF_FFFF;
  localparam logic [KEY_W-1:0] ALL_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;

  localparam logic [KIND_W-1:0] KIND_ZERO = 16'h0000;
  localparam logic [KIND_W-1:0] KIND_MAX  = 16'h7FFF;
  localparam logic [KIND_W-1:0] KIND_MIN  = 16'h8000;
  localparam logic [KIND_W-1:0] KIND_NEG1 = 16'hFFFF;

  // Longest search: every bank row in use plus the walk through the cell row.
  localparam int SEARCH_CYCLES = BANK_DEPTH + 2 * CELL_COUNT + 4;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        start = 1'b0;
  logic                        busy;
  logic [KEY_W-1:0]            in_lat_bits = '0;
  logic [KEY_W-1:0]            in_lon_bits = '0;
  logic signed [KIND_W-1:0]    in_point_kind = '0;
  logic                        out_valid;
  logic signed [NODE_ID_W-1:0] out_node_id;
  logic                        out_is_new;
  logic                        out_table_full;
  logic                        out_id_exhausted;

  point_dedup_id_table_core DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_lat_bits      (in_lat_bits),
    .in_lon_bits      (in_lon_bits),
    .in_point_kind    (in_point_kind),
    .out_valid        (out_valid),
    .out_node_id      (out_node_id),
    .out_is_new       (out_is_new),
    .out_table_full   (out_table_full),
    .out_id_exhausted (out_id_exhausted)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Points waiting to be offered, and ids still owed by the core, oldest first.
  key_t       pending_points[$];
  id_result_t owed_ids[$];

  // Our own copy of the table and the id counter, advanced once per accepted word.
  key_t                 tbl_key [TABLE_DEPTH];
  logic [NODE_ID_W-1:0] tbl_id  [TABLE_DEPTH];
  int                   tbl_count = 0;
  logic [ID_WIDTH-1:0]  fresh_id = '1;

  int issued = 0;
  int accepted = 0;
  int burst_left = 0;
  int gap_left = 0;
  int mismatches = 0;
  int checked = 0;
  int hits = 0;
  int stored = 0;
  int turned_away = 0;
  int zero_kind = 0;

  // Keys are equal as IEEE values: a NaN never matches, and the two zeros match.
  function automatic logic coord_eq(logic [KEY_W-1:0] a, logic [KEY_W-1:0] b);
    logic a_nan;
    logic b_nan;
    a_nan = (&a[62:52]) && (|a[51:0]);
    b_nan = (&b[62:52]) && (|b[51:0]);
    if (a_nan || b_nan) return 1'b0;
    if (a[62:0] == '0 && b[62:0] == '0) return 1'b1;
    return a == b;
  endfunction

  // Works out the result for one accepted point and updates the table copy.
  function automatic id_result_t assign_node_id(key_t p);
    id_result_t                  r;
    logic signed [NODE_ID_W-1:0] id_port;
    r = '0;
    if (p.kind != KIND_ZERO) begin
      for (int i = 0; i < tbl_count; i++) begin
        if (tbl_key[i].kind == p.kind && coord_eq(tbl_key[i].lat, p.lat) &&
            coord_eq(tbl_key[i].lon, p.lon)) begin
          r.node_id = tbl_id[i];
          return r;
        end
      end
    end
    // A fresh id: sign-extended counter value; the counter sticks at its minimum.
    id_port = $signed(fresh_id);
    r.node_id = id_port;
    r.is_new = 1'b1;
    if (fresh_id == ID_MIN) begin
      r.id_exhausted = 1'b1;
    end else begin
      fresh_id = fresh_id - 1'b1;
    end
    if (p.kind != KIND_ZERO) begin
      if (tbl_count < TABLE_DEPTH) begin
        tbl_key[tbl_count] = p;
        tbl_id[tbl_count] = r.node_id;
        tbl_count++;
      end else begin
        r.table_full = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic log_error(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  function automatic key_t pt(logic [KEY_W-1:0] lat, logic [KEY_W-1:0] lon,
                              logic [KIND_W-1:0] kind);
    key_t p;
    p.lat = lat;
    p.lon = lon;
    p.kind = kind;
    return p;
  endfunction

  // A coordinate biased toward the cases the comparison treats specially, and
  // toward a few repeated values so that unrelated points sometimes collide.
  function automatic logic [KEY_W-1:0] pick_coord();
    logic [KEY_W-1:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: v = {v[63], 63'd0};
      1: v = {v[63], POS_INF[62:0]};
      2: begin
        v[62:52] = 11'h7FF;
        if (v[51:0] == '0) v[0] = 1'b1;
      end
      3: v = 64'h4000_0000_0000_0000 + 64'($urandom_range(0, 3));
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [KIND_W-1:0] pick_kind();
    case ($urandom_range(0, 9))
      0, 1, 2: return 16'd1;
      3:       return 16'd2;
      4:       return KIND_NEG1;
      5:       return KIND_MAX;
      6:       return KIND_MIN;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Waits until every queued word has been taken and its result has come back.
  task automatic drain_all();
    while (pending_points.size() != 0 || accepted != issued) @(posedge clk);
    for (int w = 0; w < 4 * SEARCH_CYCLES && owed_ids.size() != 0; w++) @(posedge clk);
  endtask

  // Sender. The next word goes out at the falling edge after the previous one
  // was taken. It works in bursts of random length; between bursts start usually stays
  // low for a random gap, and the key ports carry noise that must be ignored.
  // Gaps are counted from the acceptance, so start rises at any point of a search.
  always @(negedge clk) begin
    key_t p;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && accepted != issued) begin
      // The word is still waiting for busy to drop.
    end else if (gap_left > 0) begin
      start <= 1'b0;
      gap_left <= gap_left - 1;
      in_lat_bits <= {$urandom, $urandom};
      in_lon_bits <= {$urandom, $urandom};
      in_point_kind <= 16'($urandom);
    end else if (pending_points.size() != 0) begin
      p = pending_points.pop_front();
      in_lat_bits <= p.lat;
      in_lon_bits <= p.lon;
      in_point_kind <= p.kind;
      start <= 1'b1;
      issued <= issued + 1;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 30);
        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor. Every strobed result is checked against the oldest owed id
  // before the word taken at this same edge is predicted and queued.
  always @(posedge clk) begin
    id_result_t want;
    id_result_t got;
    key_t       p;
    if (rst_n) begin
      if (out_valid) begin
        got.node_id = out_node_id;
        got.is_new = out_is_new;
        got.table_full = out_table_full;
        got.id_exhausted = out_id_exhausted;
        checked++;
        if (owed_ids.size() == 0) begin
          log_error($sformatf("unexpected result: id %0d new %b full %b exhausted %b",
                              $signed(got.node_id), got.is_new, got.table_full,
                              got.id_exhausted));
        end else begin
          want = owed_ids.pop_front();
          if (got !== want) begin
            log_error($sformatf({"mismatch on result %0d: expected id %0d new %b full %b ",
                                 "exhausted %b, got id %0d new %b full %b exhausted %b"},
                                checked, $signed(want.node_id), want.is_new,
                                want.table_full, want.id_exhausted, $signed(got.node_id),
                                got.is_new, got.table_full, got.id_exhausted));
          end
        end
      end
      if (start && !busy) begin
        p = pt(in_lat_bits, in_lon_bits, in_point_kind);
        want = assign_node_id(p);
        owed_ids.push_back(want);
        accepted++;
        if (p.kind == KIND_ZERO) zero_kind++;
        else if (!want.is_new) hits++;
        else if (want.table_full) turned_away++;
        else stored++;
      end
    end
  end

  initial begin
    key_t p;
    key_t history[$];
    int   sel;
    int   room;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed words. Kind zero never matches, even on an identical point.
    pending_points.push_back(pt(POS_ZERO, POS_ZERO, KIND_ZERO));
    pending_points.push_back(pt(POS_ZERO, POS_ZERO, KIND_ZERO));
    pending_points.push_back(pt(ALL_ONES, ALL_ONES, KIND_ZERO));
    // Plus zero and minus zero are the same coordinate; the kind must match too.
    pending_points.push_back(pt(POS_ZERO, POS_ZERO, 16'd1));
    pending_points.push_back(pt(NEG_ZERO, NEG_ZERO, 16'd1));
    pending_points.push_back(pt(NEG_ZERO, POS_ZERO, 16'd1));
    pending_points.push_back(pt(POS_ZERO, NEG_ZERO, 16'd2));
    // A NaN in either key misses every time, so each copy is stored again.
    pending_points.push_back(pt(QUIET_NAN, POS_ZERO, 16'd1));
    pending_points.push_back(pt(QUIET_NAN, POS_ZERO, 16'd1));
    pending_points.push_back(pt(POS_ZERO, TINY_NAN, 16'd1));
    pending_points.push_back(pt(ALL_ONES, ALL_ONES, KIND_NEG1));
    pending_points.push_back(pt(ALL_ONES, ALL_ONES, KIND_NEG1));
    // Infinities compare by bit pattern, so swapping signs is a different point.
    pending_points.push_back(pt(POS_INF, NEG_INF, 16'd1));
    pending_points.push_back(pt(POS_INF, NEG_INF, 16'd1));
    pending_points.push_back(pt(NEG_INF, POS_INF, 16'd1));
    // Extreme kinds and extreme finite values.
    pending_points.push_back(pt(MAX_REAL, 64'd1, KIND_MAX));
    pending_points.push_back(pt(MAX_REAL, 64'd1, KIND_MAX));
    pending_points.push_back(pt(MAX_REAL, POS_ZERO, KIND_MAX));
    pending_points.push_back(pt(64'd1, 64'd1, KIND_MIN));
    pending_points.push_back(pt(64'd1, 64'd1, KIND_MIN));
    pending_points.push_back(pt(64'h8000_0000_0000_0001, MIN_REAL, KIND_NEG1));
    pending_points.push_back(pt(64'd1, NEG_ZERO, 16'd1));
    pending_points.push_back(pt(64'd1, POS_ZERO, 16'd1));
    pending_points.push_back(pt(POS_INF, POS_INF, KIND_MIN));

    // Random words. Many repeat an earlier point so that hits are common;
    // the rest are near misses, kind-zero words and fresh points.
    for (int n = 0; n < 400; n++) begin
      sel = $urandom_range(0, 19);
      if (sel < 8 && history.size() != 0) begin
        p = history[$urandom_range(0, history.size() - 1)];
        if (p.lat[62:0] == '0) p.lat[63] = 1'($urandom);
        if (p.lon[62:0] == '0) p.lon[63] = 1'($urandom);
      end else if (sel < 10 && history.size() != 0) begin
        p = history[$urandom_range(0, history.size() - 1)];
        case ($urandom_range(0, 2))
          0: p.kind[$urandom_range(0, KIND_W - 1)] ^= 1'b1;
          1: p.lat[$urandom_range(0, KEY_W - 1)] ^= 1'b1;
          default: p.lon[$urandom_range(0, KEY_W - 1)] ^= 1'b1;
        endcase
      end else if (sel < 12) begin
        p = pt(pick_coord(), pick_coord(), KIND_ZERO);
      end else begin
        p = pt(pick_coord(), pick_coord(), pick_kind());
      end
      if (p.kind != KIND_ZERO) history.push_back(p);
      pending_points.push_back(p);
    end
    drain_all();

    // Fill the table with distinct points and run a few past its capacity.
    room = TABLE_DEPTH - tbl_count + 24;
    for (int n = 0; n < room; n++) begin
      pending_points.push_back(pt({$urandom, 32'(n)}, {$urandom, $urandom},
                                  16'($urandom_range(1, 300))));
    end
    drain_all();

    // With the table full, stored points still hit and every nonzero-kind miss is turned away.
    for (int n = 0; n < 48; n++) begin
      sel = $urandom_range(0, 9);
      if (sel < 5 && tbl_count != 0) begin
        p = tbl_key[$urandom_range(0, tbl_count - 1)];
      end else if (sel == 5 && tbl_count != 0) begin
        p = tbl_key[tbl_count - 1];
      end else if (sel < 9) begin
        p = pt(pick_coord(), pick_coord(), pick_kind());
      end else begin
        p = pt(pick_coord(), pick_coord(), KIND_ZERO);
      end
      pending_points.push_back(p);
    end
    drain_all();

    repeat (SEARCH_CYCLES) @(posedge clk);
    while (owed_ids.size() != 0) begin
      p = '0;
      log_error($sformatf("missing result: id %0d never arrived",
                          $signed(owed_ids[0].node_id)));
      void'(owed_ids.pop_front());
    end

    $display("summary: %0d words taken, %0d table hits, %0d stored, %0d refused by full table",
             accepted, hits, stored, turned_away);
    $display("summary: %0d kind-zero words, %0d results checked, %0d mismatches",
             zero_kind, checked, mismatches);
    if (mismatches == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // Watchdog for a core that stops answering or never drops busy.
  initial begin
    #12_000_000;
    $display("tb: errors");
    $finish;
  end

endmodule

// ===== point_dedup_id_table_core.f =====
rtl/core/pdt_pkg.sv
rtl/core/pdt_ram.sv
rtl/core/pdt_cell.sv
rtl/core/point_dedup_id_table.sv
tb/sv/tb.sv
